>>> design/spdc_pkg.sv
// ----------------------------------------------------------------------------
// spdc_pkg
// Shared types, constants and the crc helper for the framed packet receiver.
// ----------------------------------------------------------------------------
package spdc_pkg;

	// largest payload a frame may carry
	localparam int MaxPayload = 32;
	localparam int LenW       = $clog2(MaxPayload + 1);
	localparam int AddrW      = $clog2(MaxPayload);

	// crc-16/arc, reflected form
	localparam logic [15:0] CrcPoly  = 16'hA001;
	localparam int          CrcBits  = 4;

	// configuration register indexes and reset values
	localparam int          CfgIdxW      = 2;
	localparam int          CfgDataW     = 16;
	localparam logic [CfgIdxW-1:0] REG_START   = 2'd0;
	localparam logic [CfgIdxW-1:0] REG_END     = 2'd1;
	localparam logic [CfgIdxW-1:0] REG_TIMEOUT = 2'd2;
	localparam logic [7:0]  StartReset   = 8'hFF;
	localparam logic [7:0]  EndReset     = 8'hF7;
	localparam logic [15:0] TimeoutReset = 16'd1000;

	// input word command codes
	localparam logic CMD_BYTE = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	typedef enum logic [2:0] {
		STS_OK       = 3'd0,
		STS_TIMEOUT  = 3'd1,
		STS_BAD_SOF  = 3'd2,
		STS_BAD_EOF  = 3'd3,
		STS_CRC_ERR  = 3'd4,
		STS_BAD_LEN  = 3'd5
	} status_t;

	// frame phase
	typedef enum logic [6:0] {
		PH_HUNT  = 7'b0000001,
		PH_ID    = 7'b0000010,
		PH_LEN   = 7'b0000100,
		PH_DATA  = 7'b0001000,
		PH_CRCLO = 7'b0010000,
		PH_CRCHI = 7'b0100000,
		PH_END   = 7'b1000000
	} phase_t;

	// sequencer state
	typedef enum logic [3:0] {
		SQ_ACCEPT = 4'b0001,
		SQ_CRC    = 4'b0010,
		SQ_RD     = 4'b0100,
		SQ_OUT    = 4'b1000
	} seq_t;

	// four bits of the reflected crc shift in one go
	function automatic logic [15:0] crc_step(input logic [15:0] crc);
		logic [15:0] c;
		c = crc;
		for (int k = 0; k < CrcBits; k++) begin
			if (c[0])
				c = (c >> 1) ^ CrcPoly;
			else
				c = c >> 1;
		end
		return c;
	endfunction

endpackage

>>> design/spdc_in_if.sv
// ----------------------------------------------------------------------------
// spdc_in_if
// Input channel: received byte or time tick, with valid and ready.
// ----------------------------------------------------------------------------
interface spdc_in_if;
	logic       valid;
	logic       ready;
	logic       command;
	logic [7:0] rx_byte;

	modport source (output valid, output command, output rx_byte, input ready);
	modport sink   (input valid, input command, input rx_byte, output ready);
endinterface

>>> design/spdc_out_if.sv
// ----------------------------------------------------------------------------
// spdc_out_if
// Result channel: status, frame id, length, payload byte and last mark.
// ----------------------------------------------------------------------------
interface spdc_out_if;
	logic       valid;
	logic       ready;
	logic [2:0] status;
	logic [7:0] frame_id;
	logic [5:0] payload_length;
	logic [7:0] payload_byte;
	logic       last;

	modport source (output valid, output status, output frame_id, output payload_length,
		output payload_byte, output last, input ready);
	modport sink   (input valid, input status, input frame_id, input payload_length,
		input payload_byte, input last, output ready);
endinterface

>>> design/spdc_ram.sv
// ----------------------------------------------------------------------------
// spdc_ram
// Generic single write port, single read port ram with registered read.
// ----------------------------------------------------------------------------
module spdc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re)
			rdata <= mem_q[raddr];
	end

endmodule

>>> design/serial_packet_deframer_crc16_unit.sv
// ----------------------------------------------------------------------------
// serial_packet_deframer_crc16_unit
// Framed packet receiver: start, id, length, payload, crc lo/hi, end byte.
// A tick word or a marker/crc byte is taken in the accept state alone; an id, payload or
// in-range length byte is accepted and then runs two passes of the 4-bit crc step unit.
// A good frame is read out of the payload ram: a read state, then an output state per word.
// arst_n clears the sequencer, frame phase, timer and config to defaults.
// ----------------------------------------------------------------------------
module serial_packet_deframer_crc16_unit import spdc_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data,
	spdc_in_if.sink             item,
	spdc_out_if.source          result
);

	// configuration
	logic [7:0]      start_q;
	logic [7:0]      end_q;
	logic [15:0]     timeout_q;

	// frame state
	seq_t            seq_q;
	phase_t          phase_q;
	logic [7:0]      id_q;
	logic [LenW-1:0] len_q;
	logic [LenW-1:0] count_q;
	logic [15:0]     crc_q;
	logic            crc_cnt_q;
	logic [7:0]      crc_lo_q;
	logic            crc_ok_q;
	logic [15:0]     timer_q;
	logic [LenW-1:0] rd_idx_q;

	// output register
	logic            out_valid_q;
	status_t         out_status_q;
	logic [7:0]      out_id_q;
	logic [LenW-1:0] out_len_q;
	logic [7:0]      out_byte_q;
	logic            out_last_q;

	logic            out_free;
	logic            acc;
	logic            is_tick;
	logic [7:0]      b;
	logic [16:0]     timer_inc;
	logic            timeout_hit;
	logic            ram_we;
	logic            ram_re;
	logic [7:0]      ram_rdata;
	logic            rd_last;

	assign out_free    = !out_valid_q || result.ready;
	assign item.ready  = (seq_q == SQ_ACCEPT) && out_free;
	assign acc         = item.valid && item.ready;
	assign is_tick     = (item.command == CMD_TICK);
	assign b           = item.rx_byte;
	assign timer_inc   = {1'b0, timer_q} + 17'd1;
	assign timeout_hit = timer_inc >= {1'b0, timeout_q};
	assign ram_we      = acc && !is_tick && (phase_q == PH_DATA);
	assign ram_re      = (seq_q == SQ_RD);
	assign rd_last     = (rd_idx_q + LenW'(1)) == len_q;

	assign result.valid          = out_valid_q;
	assign result.status         = out_status_q;
	assign result.frame_id       = out_id_q;
	assign result.payload_length = out_len_q;
	assign result.payload_byte   = out_byte_q;
	assign result.last           = out_last_q;

	// payload store
	spdc_ram #(
		.WIDTH(8),
		.DEPTH(MaxPayload)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (count_q[AddrW-1:0]),
		.wdata (b),
		.re    (ram_re),
		.raddr (rd_idx_q[AddrW-1:0]),
		.rdata (ram_rdata)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q   <= StartReset;
			end_q     <= EndReset;
			timeout_q <= TimeoutReset;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_START:   start_q   <= cfg_data[7:0];
				REG_END:     end_q     <= cfg_data[7:0];
				REG_TIMEOUT: timeout_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// frame sequencer, crc step unit and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q        <= SQ_ACCEPT;
			phase_q      <= PH_HUNT;
			id_q         <= '0;
			len_q        <= '0;
			count_q      <= '0;
			crc_q        <= '0;
			crc_cnt_q    <= 1'b0;
			crc_lo_q     <= '0;
			crc_ok_q     <= 1'b0;
			timer_q      <= '0;
			rd_idx_q     <= '0;
			out_valid_q  <= 1'b0;
			out_status_q <= STS_OK;
			out_id_q     <= '0;
			out_len_q    <= '0;
			out_byte_q   <= '0;
			out_last_q   <= 1'b0;
		end else begin
			// result word taken
			if (result.ready)
				out_valid_q <= 1'b0;

			unique case (seq_q)
				SQ_ACCEPT: begin
					if (acc && is_tick) begin
						// ticks only count inside a frame
						if (phase_q != PH_HUNT) begin
							if (timeout_hit) begin
								phase_q      <= PH_HUNT;
								timer_q      <= '0;
								out_valid_q  <= 1'b1;
								out_status_q <= STS_TIMEOUT;
								out_id_q     <= '0;
								out_len_q    <= '0;
								out_byte_q   <= '0;
								out_last_q   <= 1'b1;
							end else begin
								timer_q <= timer_inc[15:0];
							end
						end
					end else if (acc) begin
						unique case (phase_q)
							PH_HUNT: begin
								if (b != start_q) begin
									timer_q      <= '0;
									out_valid_q  <= 1'b1;
									out_status_q <= STS_BAD_SOF;
									out_id_q     <= '0;
									out_len_q    <= '0;
									out_byte_q   <= '0;
									out_last_q   <= 1'b1;
								end else begin
									crc_q   <= '0;
									timer_q <= '0;
									phase_q <= PH_ID;
								end
							end
							PH_ID: begin
								id_q      <= b;
								crc_q     <= crc_q ^ {8'h00, b};
								crc_cnt_q <= 1'b0;
								seq_q     <= SQ_CRC;
								phase_q   <= PH_LEN;
							end
							PH_LEN: begin
								if (b > 8'(MaxPayload)) begin
									phase_q      <= PH_HUNT;
									timer_q      <= '0;
									out_valid_q  <= 1'b1;
									out_status_q <= STS_BAD_LEN;
									out_id_q     <= '0;
									out_len_q    <= '0;
									out_byte_q   <= '0;
									out_last_q   <= 1'b1;
								end else begin
									len_q     <= b[LenW-1:0];
									crc_q     <= crc_q ^ {8'h00, b};
									crc_cnt_q <= 1'b0;
									seq_q     <= SQ_CRC;
									count_q   <= '0;
									timer_q   <= '0;
									phase_q   <= (b != 8'h00) ? PH_DATA : PH_CRCLO;
								end
							end
							PH_DATA: begin
								crc_q     <= crc_q ^ {8'h00, b};
								crc_cnt_q <= 1'b0;
								seq_q     <= SQ_CRC;
								count_q   <= count_q + LenW'(1);
								if ((count_q + LenW'(1)) >= len_q) begin
									timer_q <= '0;
									phase_q <= PH_CRCLO;
								end
							end
							PH_CRCLO: begin
								crc_lo_q <= b;
								phase_q  <= PH_CRCHI;
							end
							PH_CRCHI: begin
								crc_ok_q <= ({b, crc_lo_q} == crc_q);
								phase_q  <= PH_END;
							end
							PH_END: begin
								phase_q <= PH_HUNT;
								timer_q <= '0;
								if (b != end_q || !crc_ok_q) begin
									// end marker is checked before the crc
									out_valid_q  <= 1'b1;
									out_status_q <= (b != end_q) ? STS_BAD_EOF : STS_CRC_ERR;
									out_id_q     <= '0;
									out_len_q    <= '0;
									out_byte_q   <= '0;
									out_last_q   <= 1'b1;
								end else if (len_q == '0) begin
									// empty payload gives one word
									out_valid_q  <= 1'b1;
									out_status_q <= STS_OK;
									out_id_q     <= id_q;
									out_len_q    <= '0;
									out_byte_q   <= '0;
									out_last_q   <= 1'b1;
								end else begin
									rd_idx_q <= '0;
									seq_q    <= SQ_RD;
								end
							end
							default: begin
								phase_q <= PH_HUNT;
								timer_q <= '0;
							end
						endcase
					end
				end
				SQ_CRC: begin
					// two passes of the shared crc step unit per byte
					crc_q     <= crc_step(crc_q);
					crc_cnt_q <= !crc_cnt_q;
					if (crc_cnt_q)
						seq_q <= SQ_ACCEPT;
				end
				SQ_RD: begin
					seq_q <= SQ_OUT;
				end
				SQ_OUT: begin
					// payload readout, one word per ram read
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_status_q <= STS_OK;
						out_id_q     <= id_q;
						out_len_q    <= len_q;
						out_byte_q   <= ram_rdata;
						out_last_q   <= rd_last;
						rd_idx_q     <= rd_idx_q + LenW'(1);
						seq_q        <= rd_last ? SQ_ACCEPT : SQ_RD;
					end
				end
				default: seq_q <= SQ_ACCEPT;
			endcase
		end
	end

	// a crc byte always runs both passes of the step unit
	a_crc_two_pass: assert property (@(posedge clk) disable iff (!arst_n)
		(seq_q == SQ_CRC && !crc_cnt_q) |=> (seq_q == SQ_CRC && crc_cnt_q))
		else $error("crc pass cut short");

	// id and payload bytes all go through the crc unit
	a_byte_feeds_crc: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && !is_tick && (phase_q == PH_ID || phase_q == PH_DATA))
		|=> (seq_q == SQ_CRC))
		else $error("byte skipped the crc unit");

	// readout never runs past the frame length
	a_rd_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(seq_q == SQ_RD || seq_q == SQ_OUT) |-> (rd_idx_q < len_q))
		else $error("payload readout out of range");

	// a final readout word returns the sequencer to accepting input
	a_rd_last_done: assert property (@(posedge clk) disable iff (!arst_n)
		(seq_q == SQ_OUT && out_free && rd_last) |=> (seq_q == SQ_ACCEPT && out_last_q))
		else $error("readout did not finish on last word");

endmodule

>>> tb/spdc_frame_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spdc_frame_checker
// Watches the configuration port and both channels of the framed packet
// receiver. It tracks the frame state and works out the result words due for
// every accepted input word. Each accepted result word is then compared, field
// by field, with the oldest word still due.
// ----------------------------------------------------------------------------
module spdc_frame_checker import spdc_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data,
	spdc_in_if                  item,
	spdc_out_if                 result,
	output int                  mismatches,
	output int                  outstanding
);

	typedef struct packed {
		status_t    status;
		logic [7:0] frame_id;
		logic [5:0] payload_length;
		logic [7:0] payload_byte;
		logic       last;
	} rx_word_t;

	rx_word_t    due_words[$];
	logic [7:0]  start_mk;
	logic [7:0]  end_mk;
	logic [15:0] tick_limit;
	phase_t      phase;
	logic [7:0]  held_id;
	logic [7:0]  held_len;
	logic [5:0]  got;
	logic [15:0] crc;
	logic [7:0]  crc_lo;
	logic        crc_good;
	logic [7:0]  store [MaxPayload];
	int unsigned timer;
	int          errs = 0;

	// crc-16/arc, one byte, lsb first
	function automatic logic [15:0] arc_update(input logic [15:0] c, input logic [7:0] b);
		logic [15:0] r;
		r = c ^ {8'h00, b};
		for (int k = 0; k < 8; k++)
			r = r[0] ? ((r >> 1) ^ CrcPoly) : (r >> 1);
		return r;
	endfunction

	function automatic void queue_word(input status_t st, input logic [7:0] id,
		input logic [5:0] len, input logic [7:0] data, input logic fin);
		rx_word_t w;
		w.status         = st;
		w.frame_id       = id;
		w.payload_length = len;
		w.payload_byte   = data;
		w.last           = fin;
		due_words = {due_words, w};
	endfunction

	// any error gives a single word and sends the receiver back to hunting
	function automatic void drop_frame(input status_t st);
		queue_word(st, 8'h00, 6'd0, 8'h00, 1'b1);
		phase = PH_HUNT;
		timer = 0;
	endfunction

	// result words caused by one accepted input word
	function automatic void deframe_word(input logic cmd, input logic [7:0] b);
		if (cmd == CMD_TICK) begin
			// ticks only count inside a frame
			if (phase != PH_HUNT) begin
				timer++;
				if (timer >= tick_limit)
					drop_frame(STS_TIMEOUT);
			end
		end else begin
			case (phase)
				PH_HUNT: begin
					if (b != start_mk)
						drop_frame(STS_BAD_SOF);
					else begin
						crc   = '0;
						timer = 0;
						phase = PH_ID;
					end
				end
				PH_ID: begin
					held_id = b;
					crc     = arc_update(crc, b);
					phase   = PH_LEN;
				end
				PH_LEN: begin
					held_len = b;
					crc      = arc_update(crc, b);
					if (b > MaxPayload)
						drop_frame(STS_BAD_LEN);
					else begin
						got   = '0;
						timer = 0;
						if (b != 0)
							phase = PH_DATA;
						else
							phase = PH_CRCLO;
					end
				end
				PH_DATA: begin
					store[got[AddrW-1:0]] = b;
					crc                   = arc_update(crc, b);
					got++;
					if (got >= held_len) begin
						timer = 0;
						phase = PH_CRCLO;
					end
				end
				PH_CRCLO: begin
					crc_lo = b;
					phase  = PH_CRCHI;
				end
				PH_CRCHI: begin
					crc_good = ({b, crc_lo} == crc);
					phase    = PH_END;
				end
				PH_END: begin
					// end marker is checked before the crc
					if (b != end_mk)
						drop_frame(STS_BAD_EOF);
					else if (!crc_good)
						drop_frame(STS_CRC_ERR);
					else begin
						phase = PH_HUNT;
						timer = 0;
						if (held_len == 0)
							queue_word(STS_OK, held_id, 6'd0, 8'h00, 1'b1);
						else
							for (int i = 0; i < held_len; i++)
								queue_word(STS_OK, held_id, held_len[5:0],
									store[i[AddrW-1:0]], i == held_len - 1);
					end
				end
				default: begin
					phase = PH_HUNT;
					timer = 0;
				end
			endcase
		end
	endfunction

	function automatic void match_result();
		rx_word_t want;
		if (due_words.size() == 0) begin
			errs++;
			$display("%0t unexpected result word: expected none, got st %0d id %h len %0d data %h last %b",
				$time, result.status, result.frame_id, result.payload_length,
				result.payload_byte, result.last);
		end else begin
			want = due_words.pop_front();
			if (want.status != result.status || want.frame_id != result.frame_id ||
				want.payload_length != result.payload_length ||
				want.payload_byte != result.payload_byte || want.last != result.last) begin
				errs++;
				$display("%0t result word mismatch: expected st %0d id %h len %0d data %h last %b",
					$time, want.status, want.frame_id, want.payload_length,
					want.payload_byte, want.last);
				$display("%0t   actual: st %0d id %h len %0d data %h last %b", $time,
					result.status, result.frame_id, result.payload_length,
					result.payload_byte, result.last);
			end
		end
	endfunction

	// sample everything at the clock edge, before the block updates
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			due_words.delete();
			start_mk   = StartReset;
			end_mk     = EndReset;
			tick_limit = TimeoutReset;
			phase      = PH_HUNT;
			held_id    = '0;
			held_len   = '0;
			got        = '0;
			crc        = '0;
			crc_lo     = '0;
			crc_good   = 1'b0;
			timer      = 0;
		end else begin
			if (result.valid && result.ready)
				match_result();
			if (cfg_we) begin
				case (cfg_index)
					REG_START:   start_mk   = cfg_data[7:0];
					REG_END:     end_mk     = cfg_data[7:0];
					REG_TIMEOUT: tick_limit = cfg_data;
					default:     ;
				endcase
			end
			if (item.valid && item.ready)
				deframe_word(item.command, item.rx_byte);
		end
		mismatches  <= errs;
		outstanding <= due_words.size();
	end

endmodule

>>> tb/serial_packet_deframer_crc16_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_packet_deframer_crc16_unit_test
// Drives framed byte streams and tick words into the packet receiver under
// several marker and timeout settings: good frames, crc and end marker
// errors, bad lengths, timeouts, stray bytes and idle ticks. Both sides idle
// at random, the result side holds off for a long stretch once, and the
// checker beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module serial_packet_deframer_crc16_unit_test;
	import spdc_pkg::*;

	localparam int IdlePct      = 21;
	localparam int StallCycles  = 400;
	localparam int SettleCycles = 24;
	localparam int EndLimit     = 200000;

	typedef enum int {
		FR_GOOD,
		FR_BAD_CRC,
		FR_BAD_END,
		FR_BAD_BOTH,
		FR_TIMEOUT
	} frame_kind_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                cfg_we;
	logic [CfgIdxW-1:0]  cfg_index;
	logic [CfgDataW-1:0] cfg_data;
	int                  mismatches;
	int                  outstanding;
	logic                steady;
	int                  stall_asks;
	int                  stall_seen;
	logic [7:0]          cur_start;
	logic [7:0]          cur_end;
	logic [15:0]         cur_tmo;
	int                  words_sent;

	spdc_in_if  item_ch ();
	spdc_out_if result_ch ();

	serial_packet_deframer_crc16_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.item      (item_ch),
		.result    (result_ch)
	);

	spdc_frame_checker watch (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.item        (item_ch),
		.result      (result_ch),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	// clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// crc-16/arc over the frame body, for building frames
	function automatic logic [15:0] arc_feed(input logic [15:0] c, input logic [7:0] b);
		logic [15:0] r;
		r = c ^ {8'h00, b};
		for (int k = 0; k < 8; k++)
			r = r[0] ? ((r >> 1) ^ CrcPoly) : (r >> 1);
		return r;
	endfunction

	// one input word, with a random gap in front
	task automatic send_word(input logic cmd, input logic [7:0] b, input bit counted);
		while (!steady && $urandom_range(99) < IdlePct) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
		item_ch.valid   <= 1'b1;
		item_ch.command <= cmd;
		item_ch.rx_byte <= b;
		@(posedge clk);
		while (!item_ch.ready)
			@(posedge clk);
		if (counted)
			words_sent++;
	endtask

	// whole frame, with ticks kept under the timeout in each wait phase;
	// a timeout frame stops early and then ticks until the timer runs out
	task automatic send_frame(input logic [7:0] fid, input int len, input frame_kind_t kind,
		input int fill);
		logic [7:0]  bytes[$];
		logic [15:0] crc;
		logic [7:0]  eof;
		logic [7:0]  data;
		int          cut;
		int          grp;
		int          prev_grp;
		int          ticks;
		bytes = {bytes, cur_start};
		bytes = {bytes, fid};
		bytes = {bytes, len[7:0]};
		crc = arc_feed(arc_feed(16'h0000, fid), len[7:0]);
		if (len <= MaxPayload) begin
			for (int i = 0; i < len; i++) begin
				data = (fill < 0) ? 8'($urandom_range(255)) : fill[7:0];
				bytes = {bytes, data};
				crc = arc_feed(crc, data);
			end
			if (kind == FR_BAD_CRC || kind == FR_BAD_BOTH)
				crc = crc ^ 16'($urandom_range(65535, 1));
			eof = cur_end;
			if (kind == FR_BAD_END || kind == FR_BAD_BOTH)
				eof = cur_end ^ 8'($urandom_range(255, 1));
			bytes = {bytes, crc[7:0]};
			bytes = {bytes, crc[15:8]};
			bytes = {bytes, eof};
		end
		if (kind == FR_TIMEOUT && len <= MaxPayload)
			cut = $urandom_range(bytes.size() - 1, 1);
		else
			cut = bytes.size();
		prev_grp = 0;
		ticks    = 0;
		for (int i = 0; i < cut; i++) begin
			// wait phases: id and length, payload, crc and end marker
			grp = (i <= 2) ? 0 : ((i <= 2 + len) ? 1 : 2);
			if (grp != prev_grp)
				ticks = 0;
			prev_grp = grp;
			if (i > 0 && ticks + 1 < cur_tmo && $urandom_range(99) < 15) begin
				send_word(CMD_TICK, 8'($urandom_range(255)), 1'b1);
				ticks++;
			end
			send_word(CMD_BYTE, bytes[i], 1'b1);
		end
		if (cut < bytes.size())
			repeat (cur_tmo)
				send_word(CMD_TICK, 8'($urandom_range(255)), 1'b1);
	endtask

	// hold the sender until every due word is out and the block is quiet
	task automatic drain();
		item_ch.valid <= 1'b0;
		repeat (2) @(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic load_settings(input logic [7:0] sof, input logic [7:0] eof,
		input logic [15:0] tmo);
		cfg_we    <= 1'b1;
		cfg_index <= REG_START;
		cfg_data  <= {8'h00, sof};
		@(posedge clk);
		cfg_index <= REG_END;
		cfg_data  <= {8'h00, eof};
		@(posedge clk);
		cfg_index <= REG_TIMEOUT;
		cfg_data  <= tmo;
		@(posedge clk);
		cfg_we    <= 1'b0;
		cur_start = sof;
		cur_end   = eof;
		cur_tmo   = tmo;
	endtask

	// mostly well-formed frames, the rest broken frames and line noise
	task automatic random_traffic(input int upto);
		int          pick;
		int          r;
		int          len;
		logic [7:0]  b;
		frame_kind_t kind;
		while (words_sent < upto) begin
			pick = $urandom_range(99);
			r    = $urandom_range(99);
			if (r < 8)
				len = MaxPayload;
			else if (r < 25)
				len = $urandom_range(MaxPayload - 1, 7);
			else
				len = $urandom_range(6, 0);
			if (pick < 60)
				kind = FR_GOOD;
			else if (pick < 67)
				kind = FR_BAD_CRC;
			else if (pick < 72)
				kind = FR_BAD_END;
			else if (pick < 75)
				kind = FR_BAD_BOTH;
			else if (pick < 88)
				kind = (cur_tmo <= 16) ? FR_TIMEOUT : FR_GOOD;
			if (pick < 75 || (pick >= 81 && pick < 88))
				send_frame(8'($urandom_range(255)), len, kind, -1);
			else if (pick < 81)
				send_frame(8'($urandom_range(255)),
					(r < 30) ? MaxPayload + 1 : $urandom_range(255, MaxPayload + 2),
					FR_GOOD, -1);
			else if (pick < 94) begin
				// stray byte while hunting
				b = 8'($urandom_range(255));
				if (b == cur_start)
					b = ~b;
				send_word(CMD_BYTE, b, 1'b1);
			end else if (pick < 98)
				send_word(CMD_TICK, 8'($urandom_range(255)), 1'b0);
			else
				drain();
		end
	endtask

	// result side: random stalls, or one long hold-off on request
	initial begin
		result_ch.ready = 1'b0;
		stall_seen      = 0;
		forever begin
			@(posedge clk);
			if (stall_asks != stall_seen) begin
				stall_seen = stall_asks;
				result_ch.ready <= 1'b0;
				repeat (StallCycles) @(posedge clk);
			end else
				result_ch.ready <= steady || ($urandom_range(99) >= IdlePct);
		end
	end

	// stimulus and verdict
	initial begin
		int n;
		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_index       = REG_START;
		cfg_data        = '0;
		item_ch.valid   = 1'b0;
		item_ch.command = CMD_BYTE;
		item_ch.rx_byte = '0;
		steady          = 1'b0;
		stall_asks      = 0;
		words_sent      = 0;
		cur_start       = StartReset;
		cur_end         = EndReset;
		cur_tmo         = TimeoutReset;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset settings
		send_word(CMD_TICK, 8'hAA, 1'b0);
		send_word(CMD_BYTE, 8'h00, 1'b1);
		send_frame(8'h00, 0, FR_GOOD, 0);
		send_frame(8'hFF, 1, FR_GOOD, 255);
		send_frame(8'h5A, 255, FR_GOOD, -1);
		drain();

		// directed: opposite marker extremes, shortest timeout
		load_settings(8'h00, 8'hFF, 16'd1);
		send_frame(8'h81, 0, FR_BAD_CRC, -1);
		send_frame(8'h7E, 3, FR_TIMEOUT, -1);
		drain();

		// random, longest timeout
		load_settings(8'($urandom_range(255)), 8'h00, 16'hFFFF);
		random_traffic(words_sent + 28);
		drain();

		// long hold-off on the result side while full frames keep coming
		load_settings(8'($urandom_range(255)), 8'($urandom_range(255)), 16'd2);
		stall_asks++;
		send_frame(8'($urandom_range(255)), MaxPayload, FR_GOOD, -1);
		send_frame(8'($urandom_range(255)), MaxPayload, FR_GOOD, -1);
		send_frame(8'($urandom_range(255)), 5, FR_GOOD, -1);
		random_traffic(words_sent + 8);

		// stretch with no idling on either side
		steady = 1'b1;
		random_traffic(words_sent + 25);
		steady = 1'b0;
		drain();

		// random, short timeout
		load_settings(8'($urandom_range(255)), 8'($urandom_range(255)),
			16'($urandom_range(8, 3)));
		random_traffic(words_sent + 22);

		item_ch.valid <= 1'b0;
		repeat (2) @(posedge clk);
		n = 0;
		while (outstanding != 0 && n < EndLimit) begin
			@(posedge clk);
			n++;
		end
		repeat (SettleCycles) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("serial_packet_deframer_crc16_unit regression: pass");
		else
			$display("serial_packet_deframer_crc16_unit regression: fail");
		$finish;
	end

	// run limit
	initial begin
		#5000000;
		$display("serial_packet_deframer_crc16_unit regression: fail");
		$finish;
	end

endmodule
